// ----- sv/pscr_pkg.sv -----
// Package for the polar scan to raster plotter: widths, constants, codes and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pscr_pkg;

    // Defaults for top-level parameters
    localparam int PPM_DEF         = 100;
    localparam int FW_DEF          = 12;
    localparam int FH_DEF          = 6;
    localparam int MAX_SAMPLES_DEF = 4096;

    // Field widths
    localparam int RANGE_W = 16;
    localparam int STEP_W  = 20;
    localparam int IDX_W   = 12;
    localparam int PX_W    = 11;
    localparam int PY_W    = 10;
    localparam int LIM_W   = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 1'b1;
    localparam logic [RANGE_W-1:0]   MAX_RANGE_RST  = 16'd5000;
    localparam logic [STEP_W-1:0]    ANGLE_STEP_RST = 20'd18302;

    // Angle arithmetic, 2^-20 rad
    localparam int ANG_W  = 32;
    localparam int REM_W  = 24;
    localparam int ZU_W   = 23;
    localparam int Z_W    = 24;
    localparam int VEC_W  = 32;
    localparam int RCP_2PI_W  = 10;
    localparam int RCP_2PI_SH = 32;
    localparam logic [ZU_W-1:0]       ANG_2PI     = 23'd6588397;
    localparam logic signed [Z_W-1:0] ANG_PI      = 24'sd3294199;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = 24'sd1647099;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam int CORDIC_STEPS = 20;
    localparam logic [RCP_2PI_W-1:0] RCP_2PI =
        RCP_2PI_W'((64'd1 << RCP_2PI_SH) / 64'd6588397);

    // Projection
    localparam int MM_PER_M = 1000;
    localparam int Q_SH     = 30;
    localparam int PROD_W   = 49;
    localparam int PPM_W    = 10;
    localparam int N_W      = 60;
    localparam int T_W      = 25;
    localparam int Q_W      = 16;
    localparam int RCP_K_W  = 26;
    localparam int RCP_K_SH = 35;
    localparam logic [RCP_K_W-1:0] RCP_1000 =
        RCP_K_W'((64'd1 << RCP_K_SH) / 64'd1000);
    localparam int COORD_W  = 14;

    // Stamp slots, in emission order
    localparam int STAMP_N      = 5;
    localparam int STAMP_CENTER = 0;
    localparam int STAMP_LEFT   = 1;
    localparam int STAMP_RIGHT  = 2;
    localparam int STAMP_BELOW  = 3;
    localparam int STAMP_ABOVE  = 4;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } t_vec;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               ok;
        logic               last;
    } t_side;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [STAMP_N-1:0] mask;
        logic               marker;
        logic               last;
    } t_stamp;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pscr_in_if.sv -----
// Sample channel: valid/ready plus one range sample.
// Depends on pscr_pkg.
`default_nettype none

interface pscr_in_if import pscr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic [IDX_W-1:0]   sample_index;
    logic               scan_last;

    modport source (output valid, output range_mm, output sample_index, output scan_last,
                    input ready);
    modport sink   (input valid, input range_mm, input sample_index, input scan_last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/pscr_out_if.sv -----
// Pixel channel: valid/ready plus one pixel result.
// Depends on pscr_pkg.
`default_nettype none

interface pscr_out_if import pscr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
    logic            pixel_valid;
    logic            last_of_run;
    logic            scan_done;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_valid,
                    output last_of_run, output scan_done, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_valid,
                    input last_of_run, input scan_done, output ready);
endinterface

`default_nettype wire

// ----- sv/pscr_cordic.sv -----
// Pipelined CORDIC rotator, one step per register stage, with a sideband that travels along.
// Depends on pscr_pkg.
`default_nettype none

module pscr_cordic import pscr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_vec  i_vec,
    input  t_side i_side,
    output logic  o_valid,
    output t_vec  o_vec,
    output t_side o_side
);

    logic  r_v    [CORDIC_STEPS];
    t_vec  r_vec  [CORDIC_STEPS];
    t_side r_side [CORDIC_STEPS];

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_step
            t_vec  s_in;
            t_side s_side;
            logic  s_v;
            t_vec  n_vec;

            if (g == 0) begin : g_first
                assign s_in   = i_vec;
                assign s_side = i_side;
                assign s_v    = i_valid;
            end else begin : g_next
                assign s_in   = r_vec[g-1];
                assign s_side = r_side[g-1];
                assign s_v    = r_v[g-1];
            end

            always_comb begin
                logic signed [VEC_W-1:0] xi;
                logic signed [VEC_W-1:0] yi;
                logic signed [VEC_W-1:0] dx;
                logic signed [VEC_W-1:0] dy;
                logic signed [Z_W-1:0]   zi;
                xi = s_in.x;
                yi = s_in.y;
                zi = s_in.z;
                dx = yi >>> g;
                dy = xi >>> g;
                if (!zi[Z_W-1]) begin
                    n_vec.x = xi - dx;
                    n_vec.y = yi + dy;
                    n_vec.z = zi - atan_entry(5'(g));
                end else begin
                    n_vec.x = xi + dx;
                    n_vec.y = yi - dy;
                    n_vec.z = zi + atan_entry(5'(g));
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= s_v;
                end
                if (i_en) begin
                    r_vec[g]  <= n_vec;
                    r_side[g] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_vec   = r_vec[CORDIC_STEPS-1];
    assign o_side  = r_side[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- sv/pscr_stamp.sv -----
// Stamp serializer: holds one plotted point and sends its pixels one transfer per cycle while o_out is ready.
// Depends on pscr_pkg and pscr_out_if.
`default_nettype none

module pscr_stamp import pscr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stamp i_item,
    output logic   o_take,
    pscr_out_if.source o_out
);

    logic [STAMP_N-1:0] r_mask;
    logic               r_marker;
    logic               r_last;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;

    logic [STAMP_N-1:0] w_sel;
    logic               w_fin;
    logic               w_busy;
    logic [COORD_W-1:0] w_px;
    logic [COORD_W-1:0] w_py;

    assign w_sel  = r_mask & (~r_mask + STAMP_N'(1));
    assign w_fin  = ((r_mask & ~w_sel) == '0);
    assign w_busy = (|r_mask) || r_marker;
    assign o_take = !w_busy || (o_out.ready && w_fin);

    always_comb begin
        w_px = r_x;
        w_py = r_y;
        priority if (w_sel[STAMP_LEFT]) begin
            w_px = r_x - COORD_W'(1);
        end else if (w_sel[STAMP_RIGHT]) begin
            w_px = r_x + COORD_W'(1);
        end else if (w_sel[STAMP_BELOW]) begin
            w_py = r_y + COORD_W'(1);
        end else if (w_sel[STAMP_ABOVE]) begin
            w_py = r_y - COORD_W'(1);
        end else begin
            w_px = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_marker <= 1'b0;
        end else if (o_take) begin
            r_mask   <= i_valid ? i_item.mask : '0;
            r_marker <= i_valid && i_item.marker;
        end else if (o_out.ready) begin
            r_mask   <= r_mask & ~w_sel;
            r_marker <= 1'b0;
        end
        if (o_take) begin
            r_x    <= i_item.x;
            r_y    <= i_item.y;
            r_last <= i_item.last;
        end
    end

    assign o_out.valid       = w_busy;
    assign o_out.pixel_x     = w_px[PX_W-1:0];
    assign o_out.pixel_y     = w_py[PY_W-1:0];
    assign o_out.pixel_valid = |r_mask;
    assign o_out.last_of_run = w_fin;
    assign o_out.scan_done   = w_fin && r_last;

endmodule

`default_nettype wire

// ----- sv/polar_scan_to_raster_plotter_core.sv -----
// Top level of the polar scan to raster plotter: angle reduction, CORDIC, projection, stamp.
// Depends on pscr_pkg, pscr_in_if, pscr_out_if, pscr_cordic and pscr_stamp.
//
//   channel   dir  handshake            payload
//   i_in      in   valid/ready          range_mm, sample_index, scan_last
//   o_out     out  valid/ready          pixel_x, pixel_y, pixel_valid, last_of_run, scan_done
//   i_cfg_*   in   write enable only    i_cfg_idx, i_cfg_wdata
//
// One sample can enter every cycle while the pipeline advances.
// A plotted sample gives up to five results, one per cycle from the stamp serializer while
// o_out is ready, so sustained intake is set by that serializer.
// Reset is synchronous: it clears all valid bits and loads the register defaults.
// A stall on o_out freezes the pipeline once a sample waits at its tail; nothing is dropped or repeated.
`default_nettype none

module polar_scan_to_raster_plotter_core import pscr_pkg::*; #(
    parameter int PIXELS_PER_METER    = PPM_DEF,
    parameter int FRAME_WIDTH_METERS  = FW_DEF,
    parameter int FRAME_HEIGHT_METERS = FH_DEF,
    parameter int MAX_SAMPLES         = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pscr_in_if.sink               i_in,
    pscr_out_if.source            o_out
);

    localparam logic [Q_W-1:0]   WIDTH_PX   = Q_W'(FRAME_WIDTH_METERS * PIXELS_PER_METER);
    localparam logic [Q_W-1:0]   HEIGHT_PX  = Q_W'(FRAME_HEIGHT_METERS * PIXELS_PER_METER);
    localparam logic [LIM_W-1:0] SAMPLE_LIM = LIM_W'(MAX_SAMPLES);
    localparam logic [PPM_W-1:0] PPM        = PPM_W'(PIXELS_PER_METER);
    localparam logic [27:0]      OFF_PX_MM  =
        28'((FRAME_WIDTH_METERS / 2) * MM_PER_M * PIXELS_PER_METER);
    localparam logic signed [N_W-1:0] OFF_N = $signed(N_W'(OFF_PX_MM)) <<< Q_SH;

    // Configuration
    logic [RANGE_W-1:0] r_max_range;
    logic [STEP_W-1:0]  r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range  <= MAX_RANGE_RST;
            r_angle_step <= ANGLE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_RANGE:  r_max_range  <= i_cfg_wdata[RANGE_W-1:0];
                CFG_ANGLE_STEP: r_angle_step <= i_cfg_wdata[STEP_W-1:0];
            endcase
        end
    end

    logic w_adv;
    logic w_take;

    // Stage 1: angle product, range and index checks
    logic         r1_v;
    t_side        r1_side;
    logic [ANG_W-1:0] r1_ang;
    t_side        n1_side;
    logic [ANG_W-1:0] n1_ang;

    always_comb begin
        n1_side.range_mm = i_in.range_mm;
        n1_side.last     = i_in.scan_last;
        n1_side.ok       = (i_in.range_mm < r_max_range)
                        && ({(LIM_W-IDX_W)'(0), i_in.sample_index} < SAMPLE_LIM);
        n1_ang = {(ANG_W-IDX_W)'(0), i_in.sample_index}
               * {(ANG_W-STEP_W)'(0), r_angle_step};
    end

    // Stage 2: quotient estimate for the 2*pi reduction
    logic         r2_v;
    t_side        r2_side;
    logic [ANG_W-1:0] r2_ang;
    logic [RCP_2PI_W-1:0] r2_qe;
    logic [ANG_W+RCP_2PI_W-1:0] n2_prod;

    assign n2_prod = {(RCP_2PI_W)'(0), r1_ang} * {(ANG_W)'(0), RCP_2PI};

    // Stage 3: remainder, below twice 2*pi
    logic         r3_v;
    t_side        r3_side;
    logic [REM_W-1:0] r3_rem;
    logic [ANG_W-1:0] n3_sub;
    logic [ANG_W-1:0] n3_rem;

    assign n3_sub = {(ANG_W-RCP_2PI_W)'(0), r2_qe} * {(ANG_W-ZU_W)'(0), ANG_2PI};
    assign n3_rem = r2_ang - n3_sub;

    // Stage 4: final correction of the remainder
    logic         r4_v;
    t_side        r4_side;
    logic [ZU_W-1:0] r4_z;
    logic [REM_W-1:0] n4_z;

    assign n4_z = (r3_rem >= {1'b0, ANG_2PI}) ? (r3_rem - {1'b0, ANG_2PI}) : r3_rem;

    // Stage 5: wrap to (-pi, pi] and quarter-turn pre-rotation
    logic         r5_v;
    t_side        r5_side;
    t_vec         r5_vec;
    t_vec         n5_vec;

    always_comb begin
        logic signed [Z_W-1:0] zs;
        zs = $signed({1'b0, r4_z});
        if (zs > ANG_PI) begin
            zs = zs - $signed({1'b0, ANG_2PI});
        end
        if (zs > ANG_HALF_PI) begin
            n5_vec.x = '0;
            n5_vec.y = CORDIC_GAIN;
            n5_vec.z = zs - ANG_HALF_PI;
        end else if (zs < -ANG_HALF_PI) begin
            n5_vec.x = '0;
            n5_vec.y = -CORDIC_GAIN;
            n5_vec.z = zs + ANG_HALF_PI;
        end else begin
            n5_vec.x = CORDIC_GAIN;
            n5_vec.y = '0;
            n5_vec.z = zs;
        end
    end

    // CORDIC
    logic  w_cv;
    t_vec  w_cvec;
    t_side w_cside;

    pscr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r5_v),
        .i_vec   (r5_vec),
        .i_side  (r5_side),
        .o_valid (w_cv),
        .o_vec   (w_cvec),
        .o_side  (w_cside)
    );

    // Stage 6: range times cos and sin
    logic         r6_v;
    t_side        r6_side;
    logic signed [PROD_W-1:0] r6_pc;
    logic signed [PROD_W-1:0] r6_ps;
    logic signed [PROD_W-1:0] n6_pc;
    logic signed [PROD_W-1:0] n6_ps;

    always_comb begin
        logic signed [RANGE_W:0]  rs;
        logic signed [VEC_W-1:0]  cx;
        logic signed [VEC_W-1:0]  sy;
        rs = $signed({1'b0, w_cside.range_mm});
        cx = w_cvec.x;
        sy = w_cvec.y;
        n6_pc = rs * cx;
        n6_ps = rs * sy;
    end

    // Stage 7: scale, offset, drop the Q30 fraction
    logic         r7_v;
    t_side        r7_side;
    logic [T_W-1:0] r7_tx;
    logic [T_W-1:0] r7_ty;
    logic         r7_negx;
    logic         r7_negy;
    logic signed [N_W-1:0] n7_mx;
    logic signed [N_W-1:0] n7_nx;
    logic signed [N_W-1:0] n7_ny;

    assign n7_mx = r6_pc * $signed({1'b0, PPM});
    assign n7_nx = n7_mx + OFF_N;
    assign n7_ny = r6_ps * $signed({1'b0, PPM});

    // Stage 8: divide by 1000, quotient estimate
    logic         r8_v;
    t_side        r8_side;
    logic [T_W-1:0] r8_tx;
    logic [T_W-1:0] r8_ty;
    logic [Q_W-1:0] r8_qx;
    logic [Q_W-1:0] r8_qy;
    logic         r8_negx;
    logic         r8_negy;
    logic [T_W+RCP_K_W-1:0] n8_px;
    logic [T_W+RCP_K_W-1:0] n8_py;

    assign n8_px = {(RCP_K_W)'(0), r7_tx} * {(T_W)'(0), RCP_1000};
    assign n8_py = {(RCP_K_W)'(0), r7_ty} * {(T_W)'(0), RCP_1000};

    // Stage 9: quotient correction
    logic         r9_v;
    t_side        r9_side;
    logic [Q_W-1:0] r9_qx;
    logic [Q_W-1:0] r9_qy;
    logic         r9_negx;
    logic         r9_negy;
    logic [Q_W-1:0] n9_qx;
    logic [Q_W-1:0] n9_qy;

    always_comb begin
        logic [RCP_K_W-1:0] mx;
        logic [RCP_K_W-1:0] my;
        logic [RCP_K_W-1:0] rx;
        logic [RCP_K_W-1:0] ry;
        mx = {(RCP_K_W-Q_W)'(0), r8_qx} * RCP_K_W'(MM_PER_M);
        my = {(RCP_K_W-Q_W)'(0), r8_qy} * RCP_K_W'(MM_PER_M);
        rx = {(RCP_K_W-T_W)'(0), r8_tx} - mx;
        ry = {(RCP_K_W-T_W)'(0), r8_ty} - my;
        n9_qx = r8_qx + Q_W'(rx >= RCP_K_W'(MM_PER_M));
        n9_qy = r8_qy + Q_W'(ry >= RCP_K_W'(MM_PER_M));
    end

    // Stage 10: frame test and stamp mask
    logic   r_tv;
    t_stamp r_tail;
    t_stamp n_tail;

    always_comb begin
        logic plot;
        plot = r9_side.ok
            && !r9_negx && (r9_qx > Q_W'(1)) && (r9_qx < WIDTH_PX)
            && !r9_negy && (r9_qy > Q_W'(1)) && (r9_qy < HEIGHT_PX);
        n_tail.x      = plot ? r9_qx[COORD_W-1:0] : '0;
        n_tail.y      = plot ? r9_qy[COORD_W-1:0] : '0;
        n_tail.mask   = '0;
        n_tail.mask[STAMP_CENTER] = plot;
        n_tail.mask[STAMP_LEFT]   = plot;
        n_tail.mask[STAMP_RIGHT]  = plot && (r9_qx < WIDTH_PX - Q_W'(1));
        n_tail.mask[STAMP_BELOW]  = plot && (r9_qy < HEIGHT_PX - Q_W'(1));
        n_tail.mask[STAMP_ABOVE]  = plot;
        n_tail.marker = !plot && r9_side.last;
        n_tail.last   = r9_side.last;
    end

    // Pipeline advance
    assign w_adv      = w_take || !r_tv;
    assign i_in.ready = w_adv && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
            r_tv <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= w_cv;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
            r_tv <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side <= n1_side;
            r1_ang  <= n1_ang;

            r2_side <= r1_side;
            r2_ang  <= r1_ang;
            r2_qe   <= n2_prod[ANG_W+RCP_2PI_W-1:RCP_2PI_SH];

            r3_side <= r2_side;
            r3_rem  <= n3_rem[REM_W-1:0];

            r4_side <= r3_side;
            r4_z    <= n4_z[ZU_W-1:0];

            r5_side <= r4_side;
            r5_vec  <= n5_vec;

            r6_side <= w_cside;
            r6_pc   <= n6_pc;
            r6_ps   <= n6_ps;

            r7_side <= r6_side;
            r7_tx   <= n7_nx[Q_SH+T_W-1:Q_SH];
            r7_ty   <= n7_ny[Q_SH+T_W-1:Q_SH];
            r7_negx <= n7_nx[N_W-1];
            r7_negy <= n7_ny[N_W-1];

            r8_side <= r7_side;
            r8_tx   <= r7_tx;
            r8_ty   <= r7_ty;
            r8_qx   <= n8_px[RCP_K_SH+Q_W-1:RCP_K_SH];
            r8_qy   <= n8_py[RCP_K_SH+Q_W-1:RCP_K_SH];
            r8_negx <= r7_negx;
            r8_negy <= r7_negy;

            r9_side <= r8_side;
            r9_qx   <= n9_qx;
            r9_qy   <= n9_qy;
            r9_negx <= r8_negx;
            r9_negy <= r8_negy;

            r_tail  <= n_tail;
        end
    end

    pscr_stamp u_stamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_tv),
        .i_item  (r_tail),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- sv/pscr_checker.sv -----
// Port-level checker for the plotter core, attached to the top level by bind.
// Depends on pscr_pkg and on the top level's ports.
`default_nettype none

module pscr_checker import pscr_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [PX_W-1:0] i_pixel_x,
    input logic [PY_W-1:0] i_pixel_y,
    input logic            i_pixel_valid,
    input logic            i_last_of_run,
    input logic            i_scan_done
);

    // Stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_pixel_x, i_pixel_y, i_pixel_valid, i_last_of_run, i_scan_done}))
        else $error("pixel transfer changed while stalled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scan_done |-> i_last_of_run)
        else $error("scan_done without last_of_run");

    // A result without a pixel is only the bare end-of-scan marker
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_pixel_valid |-> (i_pixel_x == '0) && (i_pixel_y == '0)
            && i_last_of_run && i_scan_done)
        else $error("malformed scan marker");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind polar_scan_to_raster_plotter_core pscr_checker u_pscr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_pixel_x     (o_out.pixel_x),
    .i_pixel_y     (o_out.pixel_y),
    .i_pixel_valid (o_out.pixel_valid),
    .i_last_of_run (o_out.last_of_run),
    .i_scan_done   (o_out.scan_done)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for polar_scan_to_raster_plotter_core: a directed table followed by random scans.
// A behavioral projection model predicts the pixel transfers; random gaps on the sample side, stalls and one long
// hold-off on the pixel side. Depends on pscr_pkg, pscr_in_if, pscr_out_if and the core.

module tb_top;
    import pscr_pkg::*;

    localparam int FRAME_W        = FW_DEF * PPM_DEF;
    localparam int FRAME_H        = FH_DEF * PPM_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES       = 5;

    localparam longint TURN      = longint'(ANG_2PI);
    localparam longint HALF_TURN = longint'(ANG_PI);
    localparam longint QUARTER   = longint'(ANG_HALF_PI);
    localparam longint GAIN      = longint'(CORDIC_GAIN);
    localparam longint SCALE_DEN = longint'(MM_PER_M) << Q_SH;
    localparam longint X_OFFSET  =
        longint'(FW_DEF / 2) * MM_PER_M * PPM_DEF * (longint'(1) << Q_SH);

    localparam int ATAN_Q20 [CORDIC_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic [PX_W-1:0] x;
        logic [PY_W-1:0] y;
        logic            on;
        logic            run_end;
        logic            scan_end;
    } t_pixel;

    localparam t_pixel SCAN_MARKER = '{PX_W'(0), PY_W'(0), 1'b0, 1'b1, 1'b1};

    typedef enum logic {ROW_SAMPLE, ROW_SETUP} t_row;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_MARKER} t_chk;

    // Setup rows carry max_range in rng and angle_step in step.
    typedef struct packed {
        t_row               kind;
        t_chk               chk;
        logic [RANGE_W-1:0] rng;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic [STEP_W-1:0]  step;
    } t_stim_row;

    localparam int N_DIRECTED = 28;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{ROW_SAMPLE, CHK_SILENT,  16'd0,     12'd0,    1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_MARKER,  16'd0,     12'd0,    1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_SILENT,  16'd65535, 12'd4095, 1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_MARKER,  16'd65535, 12'd4095, 1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_SILENT,  16'd5000,  12'd90,   1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4999,  12'd90,   1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4999,  12'd90,   1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd3000,  12'd45,   1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd3000,  12'd135,  1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd3000,  12'd270,  1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd1000,  12'd4095, 1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4999,  12'd180,  1'b0, 20'd0},
        // right edge: x lands on the last column
        '{ROW_SETUP,  CHK_PREDICT, 16'd65535, 12'd0,    1'b0, 20'd5243},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd5995,  12'd1,    1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd1200,  12'd1,    1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_MARKER,  16'd65535, 12'd1,    1'b1, 20'd0},
        // bottom edge: y lands on the last row
        '{ROW_SETUP,  CHK_PREDICT, 16'd65535, 12'd0,    1'b0, 20'd18302},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd5995,  12'd90,   1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd5999,  12'd90,   1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd20000, 12'd45,   1'b0, 20'd0},
        // widest step, angle wraps many turns
        '{ROW_SETUP,  CHK_PREDICT, 16'd5000,  12'd0,    1'b0, 20'd1048575},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4000,  12'd4095, 1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4000,  12'd4095, 1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_PREDICT, 16'd4999,  12'd2048, 1'b0, 20'd0},
        // zero limit: every sample ignored
        '{ROW_SETUP,  CHK_PREDICT, 16'd0,     12'd0,    1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_MARKER,  16'd0,     12'd100,  1'b1, 20'd0},
        '{ROW_SAMPLE, CHK_SILENT,  16'd0,     12'd4095, 1'b0, 20'd0},
        '{ROW_SAMPLE, CHK_SILENT,  16'd65535, 12'd2047, 1'b0, 20'd0}
    };

    localparam logic [RANGE_W-1:0] PHASE_RANGE [N_PHASES] =
        '{16'd5000, 16'd65535, 16'd6000, 16'd8000, 16'd3000};
    localparam logic [STEP_W-1:0] PHASE_STEP [N_PHASES] =
        '{20'd18302, 20'd1048575, 20'd0, 20'd9151, 20'd36604};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pscr_in_if  sample_ch ();
    pscr_out_if pixel_ch ();

    polar_scan_to_raster_plotter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (sample_ch),
        .o_out       (pixel_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pixel             pending_pixels [$];
    logic [RANGE_W-1:0] max_range_q;
    logic [STEP_W-1:0]  angle_step_q;
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;

    function automatic t_pixel stamp_pixel(input longint px, input longint py);
        return '{PX_W'(px), PY_W'(py), 1'b1, 1'b0, 1'b0};
    endfunction

    // Expected pixel transfers of one sample under the current register values.
    function automatic void plot_sample(input logic [RANGE_W-1:0] rng,
                                        input logic [IDX_W-1:0] idx, input logic last);
        longint z, cx, cy, dx, dy, px, py;
        t_pixel stamp [$];
        t_pixel p;
        if (rng < max_range_q && int'(idx) < MAX_SAMPLES_DEF) begin
            z  = (longint'(idx) * longint'(angle_step_q)) % TURN;
            cx = GAIN;
            cy = 0;
            if (z > HALF_TURN) z -= TURN;
            if (z > QUARTER) begin
                cx = 0;
                cy = GAIN;
                z -= QUARTER;
            end else if (z < -QUARTER) begin
                cx = 0;
                cy = -GAIN;
                z += QUARTER;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0) begin
                    cx -= dx;
                    cy += dy;
                    z  -= ATAN_Q20[i];
                end else begin
                    cx += dx;
                    cy -= dy;
                    z  += ATAN_Q20[i];
                end
            end
            px = (longint'(rng) * cx * PPM_DEF + X_OFFSET) / SCALE_DEN;
            py = (longint'(rng) * cy * PPM_DEF) / SCALE_DEN;
            if (px > 1 && py > 1 && px < FRAME_W && py < FRAME_H) begin
                stamp = {stamp, stamp_pixel(px, py)};
                stamp = {stamp, stamp_pixel(px - 1, py)};
                if (px + 1 < FRAME_W) stamp = {stamp, stamp_pixel(px + 1, py)};
                if (py + 1 < FRAME_H) stamp = {stamp, stamp_pixel(px, py + 1)};
                stamp = {stamp, stamp_pixel(px, py - 1)};
            end
        end
        if (stamp.size() == 0 && last) stamp = {stamp, SCAN_MARKER};
        if (stamp.size() != 0) begin
            p = stamp.pop_back();
            p.run_end  = 1'b1;
            p.scan_end = last;
            stamp = {stamp, p};
        end
        pending_pixels = {pending_pixels, stamp};
    endfunction

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic [IDX_W-1:0] idx,
                               input logic last, input t_chk chk);
        sample_ch.valid        <= 1'b1;
        sample_ch.range_mm     <= rng;
        sample_ch.sample_index <= idx;
        sample_ch.scan_last    <= last;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        case (chk)
            CHK_PREDICT: plot_sample(rng, idx, last);
            CHK_MARKER:  pending_pixels = {pending_pixels, SCAN_MARKER};
            default:     ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Drain every expected transfer, then give silent samples time to leave the pipeline.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [RANGE_W-1:0] mr, input logic [STEP_W-1:0] st,
                                input logic [CFG_DATA_W-RANGE_W-1:0] junk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MAX_RANGE;
        i_cfg_wdata <= {junk, mr};
        @(negedge i_clk);
        i_cfg_idx   <= CFG_ANGLE_STEP;
        i_cfg_wdata <= st;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        max_range_q  = mr;
        angle_step_q = st;
    endtask

    task automatic random_sample();
        logic [RANGE_W-1:0] rng;
        int roll;
        int lim;
        roll = $urandom_range(0, 99);
        lim  = (max_range_q < 6000) ? int'(max_range_q) : 6000;
        if (roll < 75 && lim > 0) rng = RANGE_W'($urandom_range(0, lim - 1));
        else if (roll < 88) rng = RANGE_W'($urandom);
        else rng = max_range_q - RANGE_W'($urandom_range(0, 1));
        send_sample(rng, IDX_W'($urandom), $urandom_range(0, 7) == 0, CHK_PREDICT);
    endtask

    // Pixel side: random stalls, calm stretches and one long hold-off.
    initial begin
        int  left;
        bit  open;
        left = 0;
        open = 1'b0;
        pixel_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pixel_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (calm) begin
                pixel_ch.ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    open = !open;
                    if (open) left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
                    else left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                            : $urandom_range(1, 3);
                end
                pixel_ch.ready <= open;
                left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && pixel_ch.valid && pixel_ch.ready) begin
            got = '{pixel_ch.pixel_x, pixel_ch.pixel_y, pixel_ch.pixel_valid,
                    pixel_ch.last_of_run, pixel_ch.scan_done};
            if (pending_pixels.size() == 0) begin
                errors++;
                $display({"%0t: unexpected pixel transfer, expected none,",
                          " actual x=%0d y=%0d valid=%0b last=%0b done=%0b"},
                         $time, got.x, got.y, got.on, got.run_end, got.scan_end);
            end else begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.on !== want.on ||
                    got.run_end !== want.run_end || got.scan_end !== want.scan_end) begin
                    errors++;
                    $display({"%0t: pixel mismatch, expected x=%0d y=%0d valid=%0b last=%0b",
                              " done=%0b, actual x=%0d y=%0d valid=%0b last=%0b done=%0b"},
                             $time, want.x, want.y, want.on, want.run_end, want.scan_end,
                             got.x, got.y, got.on, got.run_end, got.scan_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row row;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_MAX_RANGE;
        i_cfg_wdata            = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.range_mm     = '0;
        sample_ch.sample_index = '0;
        sample_ch.scan_last    = 1'b0;
        max_range_q            = MAX_RANGE_RST;
        angle_step_q           = ANGLE_STEP_RST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_SETUP) begin
                settle();
                program_regs(row.rng, row.step, '0);
            end else begin
                send_sample(row.rng, row.idx, row.last, row.chk);
                pause(sender_gap());
            end
        end

        // phase 1 runs back to back against a long pixel-side hold-off
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            program_regs(PHASE_RANGE[ph], (ph == 2) ? STEP_W'($urandom) : PHASE_STEP[ph],
                         (CFG_DATA_W - RANGE_W)'($urandom));
            calm     = (ph == 1);
            hold_req = (ph == 1);
            repeat ((ph == 1) ? 40 : 22) begin
                random_sample();
                pause(sender_gap());
            end
        end
        calm = 1'b0;

        settle();
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pscr_pkg.sv
sv/pscr_in_if.sv
sv/pscr_out_if.sv
sv/pscr_cordic.sv
sv/pscr_stamp.sv
sv/polar_scan_to_raster_plotter_core.sv
sv/pscr_checker.sv
tb/tb_top.sv
